// ===== hdl/pfs_pkg.sv =====
// Shared types and constants for the panel frame sniffer.
// No dependencies; imported by pfs_core, pfs_skid and the top level.
package pfs_pkg;

	localparam int unsigned FRAME_W  = 32;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned TEMP_W   = 8;
	localparam int unsigned STATUS_W = 5;
	localparam int unsigned BTN_N    = 4;
	localparam int unsigned BTN_W    = 2;
	localparam int unsigned TICK_W   = 16;
	localparam int unsigned CFG_W    = 16;

	// Event codes carried in the command field
	typedef enum logic [1:0] {
		CMD_DCLK   = 2'd0,
		CMD_ENABLE = 2'd1,
		CMD_SPI    = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic CFG_CONTROL_WORD = 1'b0;
	localparam logic CFG_PRESS_TICKS  = 1'b1;

	// SPI command bytes
	localparam logic [7:0] SPI_PRESS_UP    = 8'h11;
	localparam logic [7:0] SPI_PRESS_DOWN  = 8'h12;
	localparam logic [7:0] SPI_PRESS_PUMP  = 8'h13;
	localparam logic [7:0] SPI_PRESS_LIGHT = 8'h14;
	localparam logic [7:0] SPI_RD_CONTROL  = 8'h21;
	localparam logic [7:0] SPI_RD_TEMP     = 8'h22;
	localparam logic [7:0] SPI_RD_STATUS   = 8'h23;
	localparam logic [7:0] SPI_RD_COUNT    = 8'h24;

	// Button bit positions in the drive mask
	localparam logic [BTN_W-1:0] BTN_UP    = 2'd0;
	localparam logic [BTN_W-1:0] BTN_DOWN  = 2'd1;
	localparam logic [BTN_W-1:0] BTN_LIGHT = 2'd2;
	localparam logic [BTN_W-1:0] BTN_PUMP  = 2'd3;

	// Reset values
	localparam logic [7:0]          CONTROL_RST = 8'd10;
	localparam logic [TICK_W-1:0]   PRESS_RST   = 16'd3125;
	localparam logic [TEMP_W-1:0]   TEMP_RST    = 8'd104;
	localparam logic [STATUS_W-1:0] STATUS_RST  = 5'd5;
	localparam logic [COUNT_W-1:0]  FRAME_MIN   = 8'd32;

	typedef struct packed {
		logic [1:0] command;
		logic       data_bit;
		logic       enable_level;
		logic [7:0] spi_byte;
	} pfs_in_t;

	typedef struct packed {
		logic                reply_valid;
		logic [7:0]          spi_reply;
		logic [BTN_N-1:0]    button_drive;
		logic [TEMP_W-1:0]   temperature_out;
		logic [STATUS_W-1:0] status_out;
	} pfs_out_t;

	typedef struct packed {
		logic             we;
		logic             index;
		logic [CFG_W-1:0] wdata;
	} cfg_wr_t;

endpackage

// ===== hdl/pfs_core.sv =====
// Event engine: frame capture, BCD decode, SPI command decode, press timer.
// Depends on pfs_pkg.
module pfs_core import pfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  pfs_in_t  item,
	input  cfg_wr_t  cfg,
	output pfs_out_t result
);

	logic [7:0]          control_q;
	logic [TICK_W-1:0]   press_ticks_q;
	logic [FRAME_W-1:0]  frame_q,   frame_d;
	logic [COUNT_W-1:0]  count_q,   count_d;
	logic                capt_q,    capt_d;
	logic [TEMP_W-1:0]   temp_q,    temp_d;
	logic [STATUS_W-1:0] status_q,  status_d;
	logic [BTN_N-1:0]    drive_q,   drive_d;
	logic [BTN_W-1:0]    last_q,    last_d;
	logic [TICK_W-1:0]   pcount_q,  pcount_d;
	logic                pactive_q, pactive_d;

	logic [TICK_W:0]     pcount_inc;
	logic [TEMP_W-1:0]   bcd_temp;
	logic [3:0]          d2, d1, d0;
	logic                press;
	logic [BTN_W-1:0]    btn;
	logic [7:0]          reply;

	// digits above 9 pass through unchecked; result wraps to 8 bits
	assign d2 = frame_q[19:16];
	assign d1 = frame_q[15:12];
	assign d0 = frame_q[11:8];
	assign bcd_temp = TEMP_W'(({4'd0, d2} * 8'd100) + ({4'd0, d1} * 8'd10) + {4'd0, d0});

	assign pcount_inc = {1'b0, pcount_q} + 1'b1;

	// SPI byte decode
	always_comb begin
		press = 1'b0;
		btn   = BTN_UP;
		reply = item.spi_byte;
		unique case (item.spi_byte)
			SPI_PRESS_UP: begin
				press = 1'b1; btn = BTN_UP; reply = 8'd0;
			end
			SPI_PRESS_DOWN: begin
				press = 1'b1; btn = BTN_DOWN; reply = 8'd0;
			end
			SPI_PRESS_PUMP: begin
				press = 1'b1; btn = BTN_PUMP; reply = 8'd0;
			end
			SPI_PRESS_LIGHT: begin
				press = 1'b1; btn = BTN_LIGHT; reply = 8'd0;
			end
			SPI_RD_CONTROL: reply = control_q;
			SPI_RD_TEMP:    reply = temp_q;
			SPI_RD_STATUS:  reply = 8'(status_q);
			SPI_RD_COUNT:   reply = count_q;
			default:        reply = item.spi_byte;
		endcase
	end

	always_comb begin
		frame_d   = frame_q;
		count_d   = count_q;
		capt_d    = capt_q;
		temp_d    = temp_q;
		status_d  = status_q;
		drive_d   = drive_q;
		last_d    = last_q;
		pcount_d  = pcount_q;
		pactive_d = pactive_q;
		unique case (cmd_t'(item.command))
			CMD_DCLK: begin
				if (capt_q) begin
					count_d = count_q + 1'b1;
					frame_d = {frame_q[FRAME_W-2:0], item.data_bit};
				end
			end
			CMD_ENABLE: begin
				if (!item.enable_level) begin
					capt_d = 1'b1;
				end else begin
					capt_d = 1'b0;
					if (count_q >= FRAME_MIN) begin
						temp_d   = bcd_temp;
						status_d = frame_q[27:23];
						frame_d  = '0;
						count_d  = '0;
					end
				end
			end
			CMD_SPI: begin
				if (press) begin
					drive_d   = drive_q | (BTN_N'(1) << btn);
					last_d    = btn;
					pcount_d  = '0;
					pactive_d = 1'b1;
				end
			end
			CMD_TICK: begin
				if (pactive_q) begin
					pcount_d = pcount_inc[TICK_W-1:0];
					if (pcount_inc >= {1'b0, press_ticks_q}) begin
						drive_d   = drive_q & ~(BTN_N'(1) << last_q);
						pactive_d = 1'b0;
					end
				end
			end
		endcase
	end

	always_comb begin
		result.reply_valid     = (cmd_t'(item.command) == CMD_SPI);
		result.spi_reply       = result.reply_valid ? reply : 8'd0;
		result.button_drive    = drive_d;
		result.temperature_out = temp_d;
		result.status_out      = status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q     <= CONTROL_RST;
			press_ticks_q <= PRESS_RST;
		end else if (cfg.we) begin
			if (cfg.index == CFG_CONTROL_WORD) begin
				control_q <= cfg.wdata[7:0];
			end
			if (cfg.index == CFG_PRESS_TICKS) begin
				press_ticks_q <= cfg.wdata[TICK_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q   <= '0;
			count_q   <= '0;
			capt_q    <= 1'b0;
			temp_q    <= TEMP_RST;
			status_q  <= STATUS_RST;
			drive_q   <= '0;
			last_q    <= '0;
			pcount_q  <= '0;
			pactive_q <= 1'b0;
		end else if (fire) begin
			frame_q   <= frame_d;
			count_q   <= count_d;
			capt_q    <= capt_d;
			temp_q    <= temp_d;
			status_q  <= status_d;
			drive_q   <= drive_d;
			last_q    <= last_d;
			pcount_q  <= pcount_d;
			pactive_q <= pactive_d;
		end
	end

endmodule

// ===== hdl/pfs_skid.sv =====
// Two-entry output buffer (result register plus skid) for result words.
// Depends on pfs_pkg.
module pfs_skid import pfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pfs_out_t push_word,
	output logic     full,
	output logic     valid,
	input  logic     stall,
	output pfs_out_t word
);

	logic     main_v_q, skid_v_q;
	pfs_out_t main_q, skid_q;
	logic     pop;

	assign pop   = main_v_q && !stall;
	assign valid = main_v_q;
	assign word  = main_q;
	assign full  = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !main_v_q) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= skid_v_q && push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !main_v_q) begin
			main_q <= skid_v_q ? skid_q : push_word;
			if (push) begin
				skid_q <= push_word;
			end
		end else if (push) begin
			skid_q <= push_word;
		end
	end

endmodule

// ===== hdl/panel_frame_sniffer_with_command_port_unit.sv =====
// Top level of the panel frame sniffer with SPI command port.
// Depends on pfs_pkg, pfs_core and pfs_skid.
//
// Takes one event word per clock while in_stall is low (data clock edge,
// enable change, SPI byte or timer tick) and returns exactly one result
// word per event. An event is processed in the cycle it is accepted: state
// updates at that edge and the result is registered in a two-entry output
// buffer, so throughput is one word per cycle when the output is not
// stalled. in_stall rises only once both buffer entries hold undelivered
// results. Config writes (cfg_index 0: control word, 1: press ticks) take
// effect at the write edge and should be made with the block idle.
module panel_frame_sniffer_with_command_port_unit import pfs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// event channel
	input  logic             in_valid,
	output logic             in_stall,
	input  pfs_in_t          in_data,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output pfs_out_t         out_data,
	// configuration write port
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic     fire;
	logic     buf_full;
	pfs_out_t res;
	cfg_wr_t  cfg;

	// accept while the skid entry is free
	assign in_stall = buf_full;
	assign fire     = in_valid && !buf_full;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	pfs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (in_data),
		.cfg    (cfg),
		.result (res)
	);

	pfs_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_word (res),
		.full      (buf_full),
		.valid     (out_valid),
		.stall     (out_stall),
		.word      (out_data)
	);

	// stall only with a result held at the output
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result at the output");

	// only SPI events produce a reply
	a_reply_only_spi: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (cmd_t'(in_data.command) != CMD_SPI)) |-> !res.reply_valid)
		else $error("reply flagged for a non-SPI event");

	// skid fills only when output was held
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
		else $error("skid filled without a held output");

endmodule

// ===== test/panel_frame_sniffer_with_command_port_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for panel_frame_sniffer_with_command_port_unit.
// Needs pfs_pkg and the unit's RTL; every result word is predicted in-line
// and checked field by field under random sender gaps and receiver stalls.
module panel_frame_sniffer_with_command_port_unit_tb;
	import pfs_pkg::*;

	// one row of the directed table: event word, whether a hand-typed
	// result follows, and that result
	typedef struct packed {
		pfs_in_t  word;
		logic     typed;
		pfs_out_t want;
	} dir_row_t;

	localparam int IN_W       = $bits(pfs_in_t);
	localparam int DIR_ROWS   = 22;
	localparam int RAND_ITEMS = 330;
	localparam int PHASES     = 6;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	pfs_in_t          in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	pfs_out_t         out_data;
	logic             cfg_we = 1'b0;
	logic             cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// hand-typed result travelling beside the word on the event channel
	logic     in_typed = 1'b0;
	pfs_out_t in_want = '0;

	int sender_idle_pct = 0;
	int stall_pct = 0;
	int words_sent = 0;
	int mismatches = 0;

	// result words still owed by the block, oldest first
	pfs_out_t awaited_words [$];

	// predicted sniffer state and register copies
	logic [7:0]          sn_control;
	logic [TICK_W-1:0]   sn_press_ticks;
	logic [FRAME_W-1:0]  sn_frame;
	logic [COUNT_W-1:0]  sn_bits;
	logic                sn_capturing;
	logic [TEMP_W-1:0]   sn_temp;
	logic [STATUS_W-1:0] sn_status;
	logic [BTN_N-1:0]    sn_drive;
	logic [BTN_W-1:0]    sn_last_btn;
	logic [TICK_W-1:0]   sn_press_cnt;
	logic                sn_pressing;

	panel_frame_sniffer_with_command_port_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// receiver: stalls at the rate the current phase sets
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic reset_state();
		sn_control     = CONTROL_RST;
		sn_press_ticks = PRESS_RST;
		sn_frame       = '0;
		sn_bits        = '0;
		sn_capturing   = 1'b0;
		sn_temp        = TEMP_RST;
		sn_status      = STATUS_RST;
		sn_drive       = '0;
		sn_last_btn    = '0;
		sn_press_cnt   = '0;
		sn_pressing    = 1'b0;
	endtask

	task automatic hold_button(input logic [BTN_W-1:0] btn);
		sn_drive[btn] = 1'b1;
		sn_last_btn   = btn;
		sn_press_cnt  = '0;
		sn_pressing   = 1'b1;
	endtask

	// Applies one event to the predicted state and forms its result word.
	task automatic sniff_event(input pfs_in_t w, output pfs_out_t r);
		logic [TICK_W:0] next_cnt;
		logic [31:0]     degrees;
		r = '0;
		case (w.command)
		CMD_DCLK: begin
			// edges outside a capture window are dropped
			if (sn_capturing) begin
				sn_bits  = sn_bits + 1'b1;
				sn_frame = {sn_frame[FRAME_W-2:0], w.data_bit};
			end
		end
		CMD_ENABLE: begin
			if (!w.enable_level) begin
				sn_capturing = 1'b1;
			end else begin
				sn_capturing = 1'b0;
				// short frames leave frame and count as they are
				if (sn_bits >= FRAME_MIN) begin
					degrees   = sn_frame[19:16] * 100 + sn_frame[15:12] * 10 + sn_frame[11:8];
					sn_temp   = degrees[TEMP_W-1:0];
					sn_status = sn_frame[27:23];
					sn_frame  = '0;
					sn_bits   = '0;
				end
			end
		end
		CMD_SPI: begin
			r.reply_valid = 1'b1;
			case (w.spi_byte)
			SPI_PRESS_UP:    hold_button(BTN_UP);
			SPI_PRESS_DOWN:  hold_button(BTN_DOWN);
			SPI_PRESS_PUMP:  hold_button(BTN_PUMP);
			SPI_PRESS_LIGHT: hold_button(BTN_LIGHT);
			SPI_RD_CONTROL:  r.spi_reply = sn_control;
			SPI_RD_TEMP:     r.spi_reply = sn_temp;
			SPI_RD_STATUS:   r.spi_reply = {3'd0, sn_status};
			SPI_RD_COUNT:    r.spi_reply = sn_bits;
			default:         r.spi_reply = w.spi_byte;
			endcase
		end
		default: begin
			// timer tick; only the last button pressed is released
			if (sn_pressing) begin
				next_cnt = {1'b0, sn_press_cnt} + 1'b1;
				if (next_cnt >= {1'b0, sn_press_ticks}) begin
					sn_drive[sn_last_btn] = 1'b0;
					sn_pressing = 1'b0;
				end
				sn_press_cnt = next_cnt[TICK_W-1:0];
			end
		end
		endcase
		r.button_drive    = sn_drive;
		r.temperature_out = sn_temp;
		r.status_out      = sn_status;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Both handshakes are judged at the falling edge, where every input
	// driven at the previous rising edge has settled; the word moves at the
	// next rising edge. Pushing before popping keeps a same-cycle result safe.
	always @(negedge clk) begin : scoreboard
		pfs_out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sniff_event(in_data, want);
				if (in_typed) begin
					want = in_want;
				end
				awaited_words.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (awaited_words.size() == 0) begin
					$display("%0t: result word 0x%0h with none awaited", $time, out_data);
					mismatches++;
				end else begin
					want = awaited_words.pop_front();
					check_field("reply_valid", want.reply_valid, out_data.reply_valid);
					check_field("spi_reply", want.spi_reply, out_data.spi_reply);
					check_field("button_drive", want.button_drive, out_data.button_drive);
					check_field("temperature_out", want.temperature_out, out_data.temperature_out);
					check_field("status_out", want.status_out, out_data.status_out);
				end
			end
		end
	end

	// Offers one word after random idle cycles and returns at the rising
	// edge that takes it; valid is left high so back-to-back words need no
	// second assignment in the same step.
	task automatic send_word(input pfs_in_t w, input logic typed, input pfs_out_t want);
		logic taken;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		in_typed <= typed;
		in_want  <= want;
		words_sent++;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// Event with its meaningful field set and every other field random.
	task automatic send_event(input cmd_t c, input logic [7:0] arg);
		pfs_in_t w;
		w = IN_W'($urandom_range(0, (1 << IN_W) - 1));
		w.command = c;
		case (c)
		CMD_DCLK:   w.data_bit = arg[0];
		CMD_ENABLE: w.enable_level = arg[0];
		CMD_SPI:    w.spi_byte = arg;
		default:    ;
		endcase
		send_word(w, 1'b0, '0);
	endtask

	// Drops valid and waits until the block owes nothing more.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		if (idx == CFG_CONTROL_WORD) begin
			sn_control = value[7:0];
		end else begin
			sn_press_ticks = value;
		end
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] spi_command(input int unsigned i);
		case (i)
		0:       return SPI_PRESS_UP;
		1:       return SPI_PRESS_DOWN;
		2:       return SPI_PRESS_PUMP;
		3:       return SPI_PRESS_LIGHT;
		4:       return SPI_RD_CONTROL;
		5:       return SPI_RD_TEMP;
		6:       return SPI_RD_STATUS;
		default: return SPI_RD_COUNT;
		endcase
	endfunction

	// Directed table, run from reset with reset register values.
	// Reads of every register, echo around the command codes, ignored
	// edges and ticks, a short frame that must not decode, all four presses.
	function automatic dir_row_t directed_row(input int i);
		case (i)
		0:  return {CMD_SPI, 1'b0, 1'b0, SPI_RD_CONTROL, 1'b1,
			1'b1, CONTROL_RST, 4'h0, TEMP_RST, STATUS_RST};
		1:  return {CMD_SPI, 1'b0, 1'b0, SPI_RD_TEMP, 1'b1,
			1'b1, TEMP_RST, 4'h0, TEMP_RST, STATUS_RST};
		2:  return {CMD_SPI, 1'b0, 1'b0, SPI_RD_STATUS, 1'b1,
			1'b1, {3'd0, STATUS_RST}, 4'h0, TEMP_RST, STATUS_RST};
		3:  return {CMD_SPI, 1'b0, 1'b0, SPI_RD_COUNT, 1'b1,
			1'b1, 8'h00, 4'h0, TEMP_RST, STATUS_RST};
		4:  return {CMD_SPI, 1'b1, 1'b1, 8'h00, 1'b1,
			1'b1, 8'h00, 4'h0, TEMP_RST, STATUS_RST};
		5:  return {CMD_SPI, 1'b1, 1'b1, 8'hFF, 1'b1,
			1'b1, 8'hFF, 4'h0, TEMP_RST, STATUS_RST};
		6:  return {CMD_SPI, 1'b0, 1'b1, 8'h10, 1'b1,
			1'b1, 8'h10, 4'h0, TEMP_RST, STATUS_RST};
		7:  return {CMD_SPI, 1'b1, 1'b0, 8'h25, 1'b1,
			1'b1, 8'h25, 4'h0, TEMP_RST, STATUS_RST};
		8:  return {CMD_DCLK, 1'b1, 1'b0, 8'hA5, 1'b1,
			1'b0, 8'h00, 4'h0, TEMP_RST, STATUS_RST};
		9:  return {CMD_TICK, 1'b1, 1'b1, 8'hFF, 1'b1,
			1'b0, 8'h00, 4'h0, TEMP_RST, STATUS_RST};
		10: return {CMD_ENABLE, 1'b0, 1'b1, 8'h00, 1'b1,
			1'b0, 8'h00, 4'h0, TEMP_RST, STATUS_RST};
		11: return {CMD_ENABLE, 1'b1, 1'b0, 8'hFF, 1'b1,
			1'b0, 8'h00, 4'h0, TEMP_RST, STATUS_RST};
		12: return {CMD_DCLK, 1'b1, 1'b0, 8'h5A, 1'b1,
			1'b0, 8'h00, 4'h0, TEMP_RST, STATUS_RST};
		13: return {CMD_DCLK, 1'b0, 1'b1, 8'h3C, 1'b0, 26'd0};
		14: return {CMD_SPI, 1'b0, 1'b0, SPI_RD_COUNT, 1'b1,
			1'b1, 8'h02, 4'h0, TEMP_RST, STATUS_RST};
		15: return {CMD_ENABLE, 1'b0, 1'b1, 8'h00, 1'b1,
			1'b0, 8'h00, 4'h0, TEMP_RST, STATUS_RST};
		16: return {CMD_SPI, 1'b0, 1'b0, SPI_RD_COUNT, 1'b1,
			1'b1, 8'h02, 4'h0, TEMP_RST, STATUS_RST};
		17: return {CMD_SPI, 1'b0, 1'b0, SPI_PRESS_UP, 1'b1,
			1'b1, 8'h00, 4'b0001, TEMP_RST, STATUS_RST};
		18: return {CMD_SPI, 1'b0, 1'b0, SPI_PRESS_DOWN, 1'b1,
			1'b1, 8'h00, 4'b0011, TEMP_RST, STATUS_RST};
		19: return {CMD_SPI, 1'b0, 1'b0, SPI_PRESS_PUMP, 1'b1,
			1'b1, 8'h00, 4'b1011, TEMP_RST, STATUS_RST};
		20: return {CMD_SPI, 1'b0, 1'b0, SPI_PRESS_LIGHT, 1'b1,
			1'b1, 8'h00, 4'b1111, TEMP_RST, STATUS_RST};
		21: return {CMD_TICK, 1'b0, 1'b0, 8'h00, 1'b0, 26'd0};
		default: return '0;
		endcase
	endfunction

	// Capture window with n_bits edges. The last 32 carry a random frame,
	// now and then with all digits at 9 or past 9 so the temperature wraps.
	// Reads and ticks are slipped in between edges; one window in ten is
	// left open so later edges land in it.
	task automatic frame_sequence(input int n_bits);
		logic [FRAME_W-1:0] payload;
		payload = $urandom;
		case ($urandom_range(0, 3))
		0:       payload[19:8] = 12'hFFF;
		1:       payload[19:8] = 12'h999;
		default: ;
		endcase
		send_event(CMD_ENABLE, 8'd0);
		for (int k = n_bits - 1; k >= 0; k--) begin
			if ($urandom_range(0, 99) < 8) begin
				if ($urandom_range(0, 1) != 0) begin
					send_event(CMD_TICK, 8'($urandom_range(0, 255)));
				end else begin
					send_event(CMD_SPI, SPI_RD_COUNT);
				end
			end
			if (k < FRAME_W) begin
				send_event(CMD_DCLK, {7'd0, payload[k]});
			end else begin
				send_event(CMD_DCLK, 8'($urandom_range(0, 1)));
			end
		end
		if ($urandom_range(0, 9) != 0) begin
			send_event(CMD_ENABLE, 8'd1);
		end
	endtask

	// A press followed by ticks around the press time, with the odd second
	// press landing while the first is still timing.
	task automatic press_sequence();
		int unsigned ticks;
		send_event(CMD_SPI, spi_command($urandom_range(0, 3)));
		ticks = $urandom_range(0, (sn_press_ticks < 24) ? sn_press_ticks + 2 : 26);
		repeat (ticks) begin
			if ($urandom_range(0, 99) < 6) begin
				send_event(CMD_SPI, spi_command($urandom_range(0, 3)));
			end
			send_event(CMD_TICK, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic random_sequence();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			if ($urandom_range(0, 99) < 15) begin
				frame_sequence($urandom_range(0, FRAME_W - 1));
			end else begin
				frame_sequence($urandom_range(FRAME_W, FRAME_W + 8));
			end
		end else if (pick < 65) begin
			press_sequence();
		end else if (pick < 85) begin
			if ($urandom_range(0, 1) != 0) begin
				send_event(CMD_SPI, spi_command($urandom_range(0, 7)));
			end else begin
				send_event(CMD_SPI, 8'($urandom_range(0, 255)));
			end
		end else begin
			// noise: any word at all
			send_word(IN_W'($urandom_range(0, (1 << IN_W) - 1)), 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		dir_row_t row;
		int       target;
		int       halfway;
		bit       paused;

		reset_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = directed_row(i);
			send_word(row.word, row.typed, row.want);
		end

		// light is still timing at the reset press time; it carries on
		// into the random phases with up, down and pump held
		wait_for_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			// registers only change with the block idle
			case (ph)
			1: begin
				write_reg(CFG_CONTROL_WORD, 16'hFF00);
				write_reg(CFG_PRESS_TICKS, 16'd0);
			end
			2: begin
				write_reg(CFG_CONTROL_WORD, 16'h00FF);
				write_reg(CFG_PRESS_TICKS, 16'd1);
			end
			3: begin
				write_reg(CFG_CONTROL_WORD, CFG_W'($urandom_range(0, 16'hFFFF)));
				write_reg(CFG_PRESS_TICKS, 16'hFFFF);
			end
			4: begin
				write_reg(CFG_CONTROL_WORD, CFG_W'($urandom_range(0, 16'hFFFF)));
				write_reg(CFG_PRESS_TICKS, CFG_W'($urandom_range(2, 8)));
			end
			5: begin
				write_reg(CFG_CONTROL_WORD, CFG_W'($urandom_range(0, 16'hFFFF)));
				write_reg(CFG_PRESS_TICKS, CFG_W'($urandom_range(9, 30)));
			end
			default: ;
			endcase

			case (ph % 4)
			0: begin
				sender_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				sender_idle_pct = 58;
				stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				stall_pct = 58;
			end
			default: begin
				sender_idle_pct = 23;
				stall_pct = 23;
			end
			endcase

			// one window long enough for the bit count to wrap past 255
			if (ph == 1) begin
				frame_sequence(256 + $urandom_range(0, 40));
			end

			target  = words_sent + RAND_ITEMS / PHASES;
			halfway = words_sent + RAND_ITEMS / (2 * PHASES);
			paused  = 1'b0;
			while (words_sent < target) begin
				// mid-phase hold-off until the block has caught up
				if (!paused && words_sent >= halfway) begin
					wait_for_results();
					paused = 1'b1;
				end
				random_sequence();
			end
			wait_for_results();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("panel_frame_sniffer_with_command_port_unit test passed");
		end else begin
			$display("panel_frame_sniffer_with_command_port_unit test failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("panel_frame_sniffer_with_command_port_unit test failed");
		$finish;
	end

endmodule
